### sv/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// shared types, register codes and helpers for the sensor compensation block
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  // pipeline depth from input register to output register
  localparam int LAT       = 85;
  // divider: sign stage, one stage per quotient bit, sign fix stage
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  // configuration register codes
  typedef enum logic [2:0] {
    REG_CAL_TEMP    = 3'd0,
    REG_CAL_PRESS_A = 3'd1,
    REG_CAL_PRESS_B = 3'd2,
    REG_CAL_PRESS_C = 3'd3,
    REG_CAL_HUM_A   = 3'd4,
    REG_CAL_HUM_B   = 3'd5
  } reg_idx_t;

  // raw reading fields still needed after entry
  typedef struct packed {
    logic [19:0] rp;
    logic [15:0] rh;
  } raw_t;

  // temperature results carried to the output
  typedef struct packed {
    logic signed [31:0] tc;
    logic signed [31:0] tf;
  } tt_t;

  function automatic logic signed [31:0] sx16_32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic signed [31:0] sx8_32(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic signed [63:0] sx16_64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

### sv/esc_mul.sv
// ----------------------------------------------------------------------------
// esc_mul
// two-stage 64 x 64 multiplier, low 64 bits of the product
// ----------------------------------------------------------------------------
`default_nettype none

module esc_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] pll;
  logic [31:0] pm1;
  logic [31:0] pm2;

  // partial products; the high-high term falls outside 64 bits
  always_ff @(posedge clk) begin
    if (en) begin
      pll <= 64'(a[31:0] * b[31:0]);
      pm1 <= 32'(a[63:32] * b[31:0]);
      pm2 <= 32'(a[31:0] * b[63:32]);
      p   <= pll + {pm1 + pm2, 32'd0};
    end
  end

endmodule

`default_nettype wire

### sv/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// pipelined signed 64-bit divider, one quotient bit per stage, truncating
// ----------------------------------------------------------------------------
`default_nettype none

module esc_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic signed [63:0] quot
);

  import esc_pkg::*;

  logic [62:0] rem [0:DIV_STEPS];
  logic [63:0] nq  [0:DIV_STEPS];
  logic [63:0] dv  [0:DIV_STEPS];
  logic        neg [0:DIV_STEPS];

  // magnitudes and quotient sign
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      nq[0]  <= num[63] ? 64'(-num) : num;
      dv[0]  <= den[63] ? 64'(-den) : den;
      neg[0] <= num[63] ^ den[63];
    end
  end

  genvar k;
  for (k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [63:0] r_sh;
    logic        ge;
    assign r_sh = {rem[k], nq[k][63]};
    assign ge   = (r_sh >= dv[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? 63'(r_sh - dv[k]) : r_sh[62:0];
        nq[k+1]  <= {nq[k][62:0], ge};
        dv[k+1]  <= dv[k];
        neg[k+1] <= neg[k];
      end
    end
  end

  // most negative / -1 wraps back to itself here
  always_ff @(posedge clk) begin
    if (en) begin
      quot <= neg[DIV_STEPS] ? 64'(-nq[DIV_STEPS]) : nq[DIV_STEPS];
    end
  end

endmodule

`default_nettype wire

### sv/env_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation_top
// integer compensation of raw temperature, pressure and humidity readings
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------
//  s_axis   | in        | s_tvalid / s_tready       | s_tdata: raw readings
//  m_axis   | out       | m_tvalid / m_tready       | m_tdata results, m_tuser flag
//  apb      | in        | psel, penable, pwrite     | paddr, pwdata, prdata
//
//  rate   : one reading per cycle while the output is empty or m_tready is high;
//           depth set by the 66-stage radix-2 pressure divider and multiplier stages
//  reset  : rst synchronous, clears valid bits and calibration registers
//  stalls : the whole pipeline holds while the output transaction waits;
//           nothing is dropped or repeated
//
`default_nettype none

module env_sensor_compensation_top (
  input  logic         clk,
  input  logic         rst,
  // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,
  // temperature_centi[31:0], fine_temperature[63:32], pressure_q24_8[95:64],
  // humidity_q7_10[112:96], zero pad[119:113]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,
  // pressure_invalid[0]
  output logic [0:0]   m_tuser,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  import esc_pkg::*;

  localparam int ST_TT  = 4;   // temperature ready
  localparam int ST_RAW = 9;   // last use of raw pressure
  localparam int ST_HUM = 13;  // humidity ready, divisor check

  // --------------------------------------------------------------------------
  // calibration registers
  // --------------------------------------------------------------------------
  logic [47:0] cal_temp, cal_press_a, cal_press_b, cal_press_c;
  logic [31:0] cal_hum_a;
  logic [39:0] cal_hum_b;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[5:3]);

  // write lands in the access phase; unused codes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp    <= '0;
      cal_press_a <= '0;
      cal_press_b <= '0;
      cal_press_c <= '0;
      cal_hum_a   <= '0;
      cal_hum_b   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_CAL_TEMP:    cal_temp    <= pwdata[47:0];
        REG_CAL_PRESS_A: cal_press_a <= pwdata[47:0];
        REG_CAL_PRESS_B: cal_press_b <= pwdata[47:0];
        REG_CAL_PRESS_C: cal_press_c <= pwdata[47:0];
        REG_CAL_HUM_A:   cal_hum_a   <= pwdata[31:0];
        REG_CAL_HUM_B:   cal_hum_b   <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_CAL_TEMP:    prdata = {16'd0, cal_temp};
      REG_CAL_PRESS_A: prdata = {16'd0, cal_press_a};
      REG_CAL_PRESS_B: prdata = {16'd0, cal_press_b};
      REG_CAL_PRESS_C: prdata = {16'd0, cal_press_c};
      REG_CAL_HUM_A:   prdata = {32'd0, cal_hum_a};
      REG_CAL_HUM_B:   prdata = {24'd0, cal_hum_b};
      default:         prdata = '0;
    endcase
  end

  // unpacked calibration words
  logic signed [31:0] t2, t3, h1, h2, h3, h4, h5, h6;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t2 = sx16_32(cal_temp[31:16]);
  assign t3 = sx16_32(cal_temp[47:32]);
  assign h1 = {24'd0, cal_hum_a[7:0]};
  assign h2 = sx16_32(cal_hum_a[23:8]);
  assign h3 = {24'd0, cal_hum_a[31:24]};
  assign h4 = sx16_32(cal_hum_b[15:0]);
  assign h5 = sx16_32(cal_hum_b[31:16]);
  assign h6 = sx8_32(cal_hum_b[39:32]);
  assign p1 = {48'd0, cal_press_a[15:0]};
  assign p2 = sx16_64(cal_press_a[31:16]);
  assign p3 = sx16_64(cal_press_a[47:32]);
  assign p4 = sx16_64(cal_press_b[15:0]);
  assign p5 = sx16_64(cal_press_b[31:16]);
  assign p6 = sx16_64(cal_press_b[47:32]);
  assign p7 = sx16_64(cal_press_c[15:0]);
  assign p8 = sx16_64(cal_press_c[31:16]);
  assign p9 = sx16_64(cal_press_c[47:32]);

  // --------------------------------------------------------------------------
  // flow control: one enable for every stage, valid bits shift with the data
  // --------------------------------------------------------------------------
  logic           en;
  logic [LAT:0]   vld;

  assign en       = !vld[LAT] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:0], s_tvalid};
    end
  end

  // side lines carrying fields past the long arithmetic
  raw_t        raw_q [0:ST_RAW];
  tt_t         tt_q  [ST_TT:LAT];
  logic [16:0] hum_q [ST_HUM:LAT];
  logic        inv_q [ST_HUM:LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      raw_q[0].rp <= s_tdata[39:20];
      raw_q[0].rh <= s_tdata[55:40];
      for (int k = 1; k <= ST_RAW; k++) raw_q[k] <= raw_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // temperature, 32-bit wrapping, stages 0 to 4
  // --------------------------------------------------------------------------
  logic [19:0]        rt0;
  logic signed [31:0] xt_c, dt_c;
  logic signed [31:0] m1_1, dd_1, v1_2, m2_2, tf3;

  assign xt_c = $signed({15'd0, rt0[19:3]}) - $signed({15'd0, cal_temp[15:0], 1'b0});
  assign dt_c = $signed({16'd0, rt0[19:4]}) - $signed({16'd0, cal_temp[15:0]});

  logic signed [63:0] a4;
  logic signed [31:0] hv4;

  always_ff @(posedge clk) begin
    if (en) begin
      rt0        <= s_tdata[19:0];
      m1_1       <= xt_c * t2;
      dd_1       <= dt_c * dt_c;
      v1_2       <= m1_1 >>> 11;
      m2_2       <= (dd_1 >>> 12) * t3;
      tf3        <= v1_2 + (m2_2 >>> 14);
      // centi-degrees: (tf * 5 + 128) >> 8
      tt_q[ST_TT].tc <= ((tf3 <<< 2) + tf3 + 32'sd128) >>> 8;
      tt_q[ST_TT].tf <= tf3;
      for (int k = ST_TT + 1; k <= LAT; k++) tt_q[k] <= tt_q[k-1];
      a4         <= {{32{tf3[31]}}, tf3} - 64'sd128000;
      hv4        <= tf3 - 32'sd76800;
    end
  end

  // --------------------------------------------------------------------------
  // humidity, 32-bit wrapping, stages 5 to 13
  // --------------------------------------------------------------------------
  logic signed [31:0] hm5, hv6_5, hv3_5, hx6, ya6, yb6, y7, ym8, y9;
  logic signed [31:0] hx7, hx8, hx9, vv10, vv11, qq11, vv12, r12;
  logic signed [31:0] hx_c, hv_c, hcl;

  assign hx_c = $signed({2'b00, raw_q[5].rh, 14'd0}) - (h4 <<< 20) - hm5 + 32'sd16384;
  assign hv_c = vv12 - (r12 >>> 4);

  // clamp to 0 .. 100 %RH in Q10.22 before the final shift
  always_comb begin
    priority if (hv_c < 0)                hcl = '0;
    else if      (hv_c > 32'sd419430400)  hcl = 32'sd419430400;
    else                                   hcl = hv_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hm5   <= h5 * hv4;
      hv6_5 <= hv4 * h6;
      hv3_5 <= hv4 * h3;
      hx6   <= hx_c >>> 15;
      ya6   <= hv6_5 >>> 10;
      yb6   <= (hv3_5 >>> 11) + 32'sd32768;
      y7    <= ya6 * yb6;
      hx7   <= hx6;
      ym8   <= ((y7 >>> 10) + 32'sd2097152) * h2;
      hx8   <= hx7;
      y9    <= (ym8 + 32'sd8192) >>> 14;
      hx9   <= hx8;
      vv10  <= hx9 * y9;
      qq11  <= (vv10 >>> 15) * (vv10 >>> 15);
      vv11  <= vv10;
      r12   <= (qq11 >>> 7) * h1;
      vv12  <= vv11;
      hum_q[ST_HUM] <= hcl[28:12];
      for (int k = ST_HUM + 1; k <= LAT; k++) hum_q[k] <= hum_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // pressure, 64-bit wrapping, stages 5 to 85
  // --------------------------------------------------------------------------
  logic signed [63:0] aa6, ap5_6, ap2_6, ap5_7, ap2_7, ap5_8, ap2_8;
  logic signed [63:0] b1_8, aap3_8, b9, a2_9, a3_11, pn10, num12, den12;

  esc_mul u_mul_aa  (.clk(clk), .en(en), .a(a4), .b(a4), .p(aa6));
  esc_mul u_mul_ap5 (.clk(clk), .en(en), .a(a4), .b(p5), .p(ap5_6));
  esc_mul u_mul_ap2 (.clk(clk), .en(en), .a(a4), .b(p2), .p(ap2_6));
  esc_mul u_mul_b1  (.clk(clk), .en(en), .a(aa6), .b(p6), .p(b1_8));
  esc_mul u_mul_ap3 (.clk(clk), .en(en), .a(aa6), .b(p3), .p(aap3_8));
  esc_mul u_mul_a3  (.clk(clk), .en(en), .a(a2_9 + 64'sh0000_8000_0000_0000),
                     .b(p1), .p(a3_11));
  esc_mul u_mul_num (.clk(clk), .en(en), .a(pn10), .b(64'sd3125), .p(num12));

  always_ff @(posedge clk) begin
    if (en) begin
      ap5_7 <= ap5_6;
      ap2_7 <= ap2_6;
      ap5_8 <= ap5_7;
      ap2_8 <= ap2_7;
      b9    <= b1_8 + (ap5_8 <<< 17) + (p4 <<< 35);
      a2_9  <= (aap3_8 >>> 8) + (ap2_8 <<< 12);
      // 2^20 - raw pressure needs 21 bits when the reading is zero
      pn10  <= ($signed({43'd0, 21'd1048576 - {1'b0, raw_q[ST_RAW].rp}}) <<< 31)
               - b9;
      den12 <= a3_11 >>> 33;
      inv_q[ST_HUM] <= (den12 == 64'sd0);
    end
  end

  logic signed [63:0] q78;

  esc_div u_div (.clk(clk), .en(en), .num(num12), .den(den12), .quot(q78));

  logic signed [63:0] p13_79, p13_80, p79, p80, p81, p82, c1_80, e80, c2_82;
  logic signed [63:0] e81, e82, sum83, s84;
  logic [31:0]        pres85;

  esc_mul u_mul_c1 (.clk(clk), .en(en), .a(p9), .b(q78 >>> 13), .p(c1_80));
  esc_mul u_mul_e  (.clk(clk), .en(en), .a(p8), .b(q78), .p(e80));
  esc_mul u_mul_c2 (.clk(clk), .en(en), .a(c1_80), .b(p13_80), .p(c2_82));

  always_ff @(posedge clk) begin
    if (en) begin
      p13_79 <= q78 >>> 13;
      p13_80 <= p13_79;
      p79    <= q78;
      p80    <= p79;
      p81    <= p80;
      p82    <= p81;
      e81    <= e80 >>> 19;
      e82    <= e81;
      sum83  <= p82 + (c2_82 >>> 25) + e82;
      s84    <= (sum83 >>> 8) + (p7 <<< 4);
      // zero divisor forces zero, otherwise saturate to 32 bits unsigned
      priority if (inv_q[LAT-1])               pres85 <= '0;
      else if      (s84 < 0)                   pres85 <= '0;
      else if      (s84 > 64'sd4294967295)     pres85 <= '1;
      else                                      pres85 <= s84[31:0];
      for (int k = ST_HUM + 1; k <= LAT; k++) inv_q[k] <= inv_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // output transaction
  // --------------------------------------------------------------------------
  assign m_tdata    = {7'd0, hum_q[LAT], pres85, tt_q[LAT].tf, tt_q[LAT].tc};
  assign m_tuser[0] = inv_q[LAT];

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[95:64] == 32'd0)
    else $error("pressure not zero with invalid divisor");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[112:96] <= 17'd102400)
    else $error("humidity beyond full scale");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
